@@ src/oas_pkg.sv @@
// Package: shared types and constants for the optimal assignment solver.
`timescale 1ns / 1ps
`default_nettype none
package oas_pkg;
    localparam int MAX_SIZE  = 16;
    localparam int COST_BITS = 16;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROW_START,
        ST_ROW_CLR,
        ST_STEP_OWN,
        ST_SCAN_RD,
        ST_SCAN_UPD,
        ST_SCAN_NEXT,
        ST_POT,
        ST_POT_NEXT,
        ST_CHECK,
        ST_AUG,
        ST_FIN_RD,
        ST_FIN_CHK,
        ST_EMIT
    } oas_state_t;
endpackage
`default_nettype wire

@@ src/oas_cost_mem.sv @@
// Cost matrix memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module oas_cost_mem
#(
    parameter int WIDTH = 17,
    parameter int ABITS = 8
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [ABITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [ABITS-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [2**ABITS];
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ src/optimal_assignment_solver_top.sv @@
// Top level: cost loading, solve sequencer and shared reduced-cost unit.
`timescale 1ns / 1ps
`default_nettype none
// Usage: write problem_size through cfg_we/cfg_data while idle. Stream cost
// entries on s_axis (one beat per cycle while loading); the beat with tlast
// set is stored and then starts the solve. s_axis_tready stays low during
// the solve and while results drain. One result beat per row follows on
// m_axis, tlast on the final row; a size of 0 or above MAX_SIZE gives
// MAX_SIZE unassigned rows, starting the cycle after the tlast beat.
// Timing: a clearing pass over all MAX_SIZE+1 entries, then a setup pass per
// row. Each augmenting step scans columns through one shared subtract/compare
// unit and one memory read port: read, update and next states per open column,
// read and next per visited one, then a potential update pass over columns 0..N
// and a check; up to N steps per row, plus a path reversal per row and a final
// check over all N columns. Results leave at one per cycle while m_axis_tready
// is high; a stalled m_axis holds the current result beat. Reset clears the
// state, size, output counter and emit flag; potentials and owners are cleared
// at each solve start, the cost memory is never cleared.
module optimal_assignment_solver_top
    import oas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // row_index[3:0], col_index[7:4], cost_value[23:8]
    input  wire logic [0:0]  s_axis_tuser,  // blocked
    input  wire logic        s_axis_tlast,  // last_entry
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_row[3:0], out_col[7:4]
    output logic [0:0]       m_axis_tuser,  // assigned
    output logic             m_axis_tlast   // last_result
);
    localparam int IB = $clog2(MAX_SIZE + 1);
    localparam int CB = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int AB = 2 * CB;
    localparam int PB = COST_BITS + 8;
    localparam int RB = PB + 2;
    localparam int EW = COST_BITS + 1;
    localparam logic signed [PB-1:0] PMAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] PMIN = {1'b1, {(PB-1){1'b0}}};

    oas_state_t state_reg, state_next;
    logic [4:0] size_reg;
    logic [IB-1:0] n_reg, i_reg, i_next, j_reg, j_next, j0_reg, j0_next, j1_reg, j1_next;
    logic [IB-1:0] i0_reg, i0_next, guard_reg, guard_next;
    logic signed [RB-1:0] delta_reg, delta_next;
    logic found_reg, found_next;
    logic [IB-1:0] cnt_reg, cnt_next, ocount_reg, ocount_next;
    logic emit_all_reg, emit_all_next;

    logic signed [PB-1:0] rpot [MAX_SIZE+1];
    logic signed [PB-1:0] cpot [MAX_SIZE+1];
    logic [IB-1:0] owner [MAX_SIZE+1];
    logic [IB-1:0] bptr [MAX_SIZE+1];
    logic signed [RB-1:0] minr [MAX_SIZE+1];
    logic [MAX_SIZE:0] reach_reg, vis_reg;
    logic [MAX_SIZE-1:0] asg_reg;
    logic [CB-1:0] colof [MAX_SIZE];

    logic [3:0] in_row, in_col;
    assign in_row = s_axis_tdata[3:0];
    assign in_col = s_axis_tdata[7:4];
    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    logic in_ok;
    assign in_ok = (32'(in_row) < MAX_SIZE) && (32'(in_col) < MAX_SIZE);

    logic [AB-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] wr_data;
    assign wr_data = {s_axis_tuser[0], s_axis_tdata[8 +: COST_BITS]};

    oas_cost_mem #(.WIDTH(EW), .ABITS(AB)) u_mem (
        .clk(clk),
        .wr_en(in_fire && in_ok),
        .wr_addr({in_row[CB-1:0], in_col[CB-1:0]}),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // shared unit: reduced cost and compare against the running min
    logic [IB-1:0] ri_m1, cj_m1;
    assign ri_m1 = i0_reg - IB'(1);
    assign cj_m1 = j_reg - IB'(1);
    logic signed [RB-1:0] rc;
    assign rc = $signed({2'b00, rd_data[COST_BITS-1:0]}) - RB'(rpot[i0_reg]) - RB'(cpot[j_reg]);
    logic rc_take;
    assign rc_take = !reach_reg[j_reg] || (rc < minr[j_reg]);

    logic i0_ok;
    assign i0_ok = (i0_reg >= IB'(1)) && (i0_reg <= n_reg);

    function automatic logic signed [PB-1:0] sat(input logic signed [RB-1:0] x);
        if (x > RB'(PMAX)) return PMAX;
        if (x < $signed(RB'(PMIN))) return PMIN;
        return x[PB-1:0];
    endfunction

    logic [IB-1:0] own_j, own_w, bw;
    assign own_j = owner[j_reg];
    assign bw = (bptr[j0_reg] > n_reg) ? '0 : bptr[j0_reg];
    assign own_w = owner[bw];
    logic [IB-1:0] oj_m1;
    assign oj_m1 = own_j - IB'(1);

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; j0_next = j0_reg; j1_next = j1_reg;
        i0_next = i0_reg; guard_next = guard_reg; delta_next = delta_reg;
        found_next = found_reg; cnt_next = cnt_reg; ocount_next = ocount_reg;
        emit_all_next = emit_all_reg;
        rd_addr = {ri_m1[CB-1:0], cj_m1[CB-1:0]};
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && s_axis_tlast)
                begin
                    if (size_reg == 5'd0 || 32'(size_reg) > MAX_SIZE)
                    begin
                        emit_all_next = 1'b1;
                        ocount_next = IB'(MAX_SIZE);
                        cnt_next = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        emit_all_next = 1'b0;
                        ocount_next = size_reg[IB-1:0];
                        j_next = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                j_next = j_reg + IB'(1);
                if (j_reg == IB'(MAX_SIZE))
                begin
                    i_next = IB'(1);
                    state_next = ST_ROW_START;
                end
            end
            ST_ROW_START:
            begin
                j0_next = '0;
                j_next = '0;
                state_next = ST_ROW_CLR;
            end
            ST_ROW_CLR:
            begin
                j_next = j_reg + IB'(1);
                if (j_reg == n_reg)
                begin
                    state_next = ST_STEP_OWN;
                end
            end
            ST_STEP_OWN:
            begin
                i0_next = owner[j0_reg];
                j_next = IB'(1);
                found_next = 1'b0;
                delta_next = '0;
                j1_next = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = vis_reg[j_reg] ? ST_SCAN_NEXT : ST_SCAN_UPD;
            end
            ST_SCAN_UPD:
            begin
                state_next = ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT:
            begin
                if (!vis_reg[j_reg] && reach_reg[j_reg] &&
                    (!found_reg || minr[j_reg] < delta_reg))
                begin
                    found_next = 1'b1;
                    delta_next = minr[j_reg];
                    j1_next = j_reg;
                end
                j_next = j_reg + IB'(1);
                if (j_reg == n_reg)
                begin
                    j_next = '0;
                    state_next = ST_POT;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POT:
            begin
                if (!found_reg)
                begin
                    j0_next = '0;
                    guard_next = '0;
                    state_next = ST_AUG;
                end
                else
                begin
                    state_next = ST_POT_NEXT;
                end
            end
            ST_POT_NEXT:
            begin
                j_next = j_reg + IB'(1);
                if (j_reg == n_reg)
                begin
                    j0_next = j1_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_POT;
                end
            end
            ST_CHECK:
            begin
                if (owner[j0_reg] != '0)
                begin
                    state_next = ST_STEP_OWN;
                end
                else
                begin
                    guard_next = '0;
                    state_next = ST_AUG;
                end
            end
            ST_AUG:
            begin
                j0_next = bw;
                guard_next = guard_reg + IB'(1);
                if (bw == '0 || guard_reg >= n_reg + IB'(1))
                begin
                    if (i_reg == n_reg)
                    begin
                        j_next = IB'(1);
                        state_next = ST_FIN_RD;
                    end
                    else
                    begin
                        i_next = i_reg + IB'(1);
                        state_next = ST_ROW_START;
                    end
                end
            end
            ST_FIN_RD:
            begin
                i0_next = own_j;
                state_next = ST_FIN_CHK;
            end
            ST_FIN_CHK:
            begin
                j_next = j_reg + IB'(1);
                if (j_reg == n_reg)
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    cnt_next = cnt_reg + IB'(1);
                    if (cnt_reg + IB'(1) == ocount_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        // final check reads the entry of column j's owner
        if (state_reg == ST_FIN_RD)
        begin
            rd_addr = {oj_m1[CB-1:0], cj_m1[CB-1:0]};
        end
    end

    logic [IB-1:0] fo_m1;
    assign fo_m1 = i0_reg - IB'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg <= 5'd0;
            cnt_reg <= '0;
            emit_all_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            emit_all_reg <= emit_all_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; j0_reg <= j0_next; j1_reg <= j1_next;
        i0_reg <= i0_next; guard_reg <= guard_next; delta_reg <= delta_next;
        found_reg <= found_next; ocount_reg <= ocount_next;
        if (state_reg == ST_LOAD)
        begin
            n_reg <= size_reg[IB-1:0];
        end
        case (state_reg)
            ST_INIT:
            begin
                rpot[j_reg] <= '0;
                cpot[j_reg] <= '0;
                owner[j_reg] <= '0;
                bptr[j_reg] <= '0;
                if (32'(j_reg) < MAX_SIZE)
                begin
                    asg_reg[j_reg[CB-1:0]] <= 1'b0;
                end
            end
            ST_ROW_START:
            begin
                owner[0] <= i_reg;
            end
            ST_ROW_CLR:
            begin
                reach_reg[j_reg] <= 1'b0;
                vis_reg[j_reg] <= 1'b0;
                minr[j_reg] <= '0;
            end
            ST_STEP_OWN:
            begin
                vis_reg[j0_reg] <= 1'b1;
            end
            ST_SCAN_UPD:
            begin
                if (i0_ok && !rd_data[COST_BITS] && rc_take)
                begin
                    reach_reg[j_reg] <= 1'b1;
                    minr[j_reg] <= rc;
                    bptr[j_reg] <= j0_reg;
                end
            end
            ST_POT:
            begin
                if (found_reg)
                begin
                    if (vis_reg[j_reg])
                    begin
                        if (own_j <= n_reg)
                        begin
                            rpot[own_j] <= sat(RB'(rpot[own_j]) + delta_reg);
                        end
                        cpot[j_reg] <= sat(RB'(cpot[j_reg]) - delta_reg);
                    end
                    else if (reach_reg[j_reg])
                    begin
                        minr[j_reg] <= minr[j_reg] - delta_reg;
                    end
                end
            end
            ST_AUG:
            begin
                owner[j0_reg] <= own_w;
            end
            ST_FIN_CHK:
            begin
                if (i0_reg >= IB'(1) && i0_reg <= n_reg && !rd_data[COST_BITS])
                begin
                    asg_reg[fo_m1[CB-1:0]] <= 1'b1;
                    colof[fo_m1[CB-1:0]] <= cj_m1[CB-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    logic [CB-1:0] oidx;
    assign oidx = cnt_reg[CB-1:0];
    logic oasg;
    assign oasg = !emit_all_reg && asg_reg[oidx];
    assign m_axis_tdata = {(oasg ? 4'(colof[oidx]) : 4'd0), 4'(cnt_reg)};
    assign m_axis_tuser = oasg;
    assign m_axis_tlast = (cnt_reg + IB'(1) == ocount_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while results pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("no return to load after last result");
endmodule
`default_nettype wire
